// ===== sv/rau_pkg.sv =====
// ----------------------------------------------------------------------------
// rau_pkg
// Shared types and constants for the rational arithmetic unit.
// ----------------------------------------------------------------------------
package rau_pkg;

    localparam int OPERAND_BITS_DEF = 32;

    localparam logic [2:0] ACT_ADD = 3'd0;
    localparam logic [2:0] ACT_SUB = 3'd1;
    localparam logic [2:0] ACT_MUL = 3'd2;
    localparam logic [2:0] ACT_DIV = 3'd3;
    localparam logic [2:0] ACT_CMP = 3'd4;

    localparam logic [1:0] ORD_LT = 2'd0;
    localparam logic [1:0] ORD_EQ = 2'd1;
    localparam logic [1:0] ORD_GT = 2'd2;

    // Classified job between front and back.
    typedef struct packed {
        logic        is_cmp;
        logic        is_nop;
        logic        div_zero;
        logic        neg;
        logic [63:0] nmag;
        logic [63:0] dmag;
        logic [1:0]  order;
    } job_t;

endpackage

// ===== sv/rau_front.sv =====
// ----------------------------------------------------------------------------
// rau_front
// Accepts operands, forms the cross products in its multiply state, classifies.
// ----------------------------------------------------------------------------
module rau_front #(
    parameter int OPERAND_BITS = rau_pkg::OPERAND_BITS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                valid,
    output logic                ready,
    input  logic [2:0]          action,
    input  logic signed [31:0]  a_num,
    input  logic [30:0]         a_den,
    input  logic signed [31:0]  b_num,
    input  logic [30:0]         b_den,
    output logic                job_valid,
    input  logic                job_ready,
    output rau_pkg::job_t       job
);
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_MUL  = 2'd1;
    localparam logic [1:0] S_SUM  = 2'd2;
    localparam logic [1:0] S_OUT  = 2'd3;

    logic [1:0] st_reg, st_next;
    logic [2:0] act_reg;
    logic signed [32:0] an_reg, ad_reg, bn_reg, bd_reg;
    logic signed [65:0] p1_reg, p2_reg;
    logic signed [65:0] n_c, d_c;
    logic signed [32:0] an_x, bn_x, ad_x, bd_x;
    logic signed [32:0] m1a, m1b, m2a, m2b;
    logic signed [65:0] dv;
    rau_pkg::job_t job_reg, job_next;

    assign an_x = 33'(signed'(a_num[OPERAND_BITS-1:0]));
    assign bn_x = 33'(signed'(b_num[OPERAND_BITS-1:0]));
    assign ad_x = signed'({1'b0, 32'(a_den[OPERAND_BITS-2:0])});
    assign bd_x = signed'({1'b0, 32'(b_den[OPERAND_BITS-2:0])});

    assign ready     = (st_reg == S_IDLE);
    assign job_valid = (st_reg == S_OUT);
    assign job       = job_reg;

    // Both cross products are formed together: an*bd and ad*bn, or an*bn and ad*bd for multiply.
    always_comb
    begin
        m1a = an_reg; m1b = bd_reg; m2a = ad_reg; m2b = bn_reg;
        if (act_reg == rau_pkg::ACT_MUL)
        begin
            m1b = bn_reg; m2b = bd_reg;
        end
    end

    always_comb
    begin
        st_next = st_reg;
        unique case (st_reg)
            S_IDLE: if (valid) st_next = S_MUL;
            S_MUL:  st_next = S_SUM;
            S_SUM:  st_next = S_OUT;
            S_OUT:  if (job_ready) st_next = S_IDLE;
            default: st_next = S_IDLE;
        endcase
    end

    // Sum/diff for add/sub, pass through otherwise; classify from the same values.
    always_comb
    begin
        dv = p1_reg - p2_reg;
        if (act_reg == rau_pkg::ACT_ADD)
            n_c = p1_reg + p2_reg;
        else if (act_reg == rau_pkg::ACT_SUB)
            n_c = dv;
        else
            n_c = p1_reg;
        if (act_reg == rau_pkg::ACT_DIV)
            d_c = p2_reg;
        else
            d_c = ad_reg * bd_reg;
        job_next = '0;
        job_next.is_nop = (act_reg > rau_pkg::ACT_CMP);
        job_next.is_cmp = (act_reg == rau_pkg::ACT_CMP);
        job_next.div_zero = (act_reg == rau_pkg::ACT_DIV) && (bn_reg == '0);
        job_next.nmag = n_c[65] ? 64'(-n_c) : 64'(n_c);
        job_next.dmag = d_c[65] ? 64'(-d_c) : 64'(d_c);
        job_next.neg = n_c[65] ^ d_c[65];
        if (dv[65])
            job_next.order = rau_pkg::ORD_LT;
        else if (dv == '0)
            job_next.order = rau_pkg::ORD_EQ;
        else
            job_next.order = rau_pkg::ORD_GT;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            st_reg <= S_IDLE;
        else
            st_reg <= st_next;
    end

    always_ff @(posedge clk)
    begin
        unique case (st_reg)
            S_IDLE:
            begin
                act_reg <= action;
                an_reg <= an_x; ad_reg <= ad_x; bn_reg <= bn_x; bd_reg <= bd_x;
            end
            S_MUL:
            begin
                p1_reg <= m1a * m1b;
                p2_reg <= m2a * m2b;
            end
            default: ;
        endcase
    end

    // Classification needs the sums; latch on entry to S_OUT.
    always_ff @(posedge clk)
    begin
        if (st_reg == S_SUM)
            job_reg <= job_next;
    end
endmodule

// ===== sv/rau_queue.sv =====
// ----------------------------------------------------------------------------
// rau_queue
// Two-entry job queue between front and back.
// ----------------------------------------------------------------------------
module rau_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  rau_pkg::job_t in_job,
    output logic          out_valid,
    input  logic          out_ready,
    output rau_pkg::job_t out_job
);
    rau_pkg::job_t mem [2];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    logic       wr, rd;

    assign in_ready  = (cnt_reg != 2'd2);
    assign out_valid = (cnt_reg != 2'd0);
    assign out_job   = mem[rp_reg];
    assign wr = in_valid && in_ready;
    assign rd = out_valid && out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= 1'b0; rp_reg <= 1'b0; cnt_reg <= 2'd0;
        end
        else
        begin
            if (wr) wp_reg <= ~wp_reg;
            if (rd) rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + 2'(wr) - 2'(rd);
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr) mem[wp_reg] <= in_job;
    end
endmodule

// ===== sv/rau_back.sv =====
// ----------------------------------------------------------------------------
// rau_back
// Binary gcd, two restoring divisions by the gcd, sign fix, output register.
// ----------------------------------------------------------------------------
module rau_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                job_valid,
    output logic                job_ready,
    input  rau_pkg::job_t       job,
    output logic                valid,
    input  logic                ready,
    output logic signed [63:0]  res_num,
    output logic [61:0]         res_den,
    output logic [1:0]          order,
    output logic                div_zero
);
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_PRE  = 3'd1;
    localparam logic [2:0] S_GCD  = 3'd2;
    localparam logic [2:0] S_DIVN = 3'd3;
    localparam logic [2:0] S_DIVD = 3'd4;
    localparam logic [2:0] S_FIN  = 3'd5;
    localparam logic [2:0] S_OUT  = 3'd6;

    logic [2:0]  st_reg;
    rau_pkg::job_t j_reg;
    logic [63:0] x_reg, y_reg, g_reg, q_reg, r_reg, dvd_reg, nq_reg;
    logic [6:0]  sh_reg, bit_reg;
    logic [64:0] rt;
    logic [63:0] nmag_q;
    logic        zero_path;

    assign job_ready = (st_reg == S_IDLE);
    assign valid     = (st_reg == S_OUT);

    // one restoring division step
    assign rt = {r_reg, dvd_reg[63]} - {1'b0, g_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            st_reg <= S_IDLE;
        else
        begin
            unique case (st_reg)
                S_IDLE: if (job_valid) st_reg <= S_PRE;
                S_PRE:
                    if (j_reg.is_cmp || j_reg.is_nop || j_reg.nmag == '0
                        || j_reg.dmag == '0)
                        st_reg <= S_FIN;
                    else
                        st_reg <= S_GCD;
                S_GCD:
                    if (((x_reg | y_reg) & 64'd1) == 64'd0) st_reg <= S_GCD;
                    else if (!x_reg[0]) st_reg <= S_GCD;
                    else if (y_reg != '0) st_reg <= S_GCD;
                    else st_reg <= S_DIVN;
                S_DIVN: if (bit_reg == 7'd63) st_reg <= S_DIVD;
                S_DIVD: if (bit_reg == 7'd63) st_reg <= S_FIN;
                S_FIN:  st_reg <= S_OUT;
                S_OUT:  if (ready) st_reg <= S_IDLE;
                default: st_reg <= S_IDLE;
            endcase
        end
    end

    assign zero_path = (j_reg.nmag == '0) || (j_reg.dmag == '0);
    assign nmag_q = zero_path ? j_reg.nmag : nq_reg;

    always_ff @(posedge clk)
    begin
        unique case (st_reg)
            S_IDLE: j_reg <= job;
            S_PRE:
            begin
                x_reg <= j_reg.nmag; y_reg <= j_reg.dmag; sh_reg <= '0;
                nq_reg <= '0; q_reg <= '0;
            end
            S_GCD:
            begin
                if (((x_reg | y_reg) & 64'd1) == 64'd0)
                begin
                    x_reg <= x_reg >> 1; y_reg <= y_reg >> 1; sh_reg <= sh_reg + 7'd1;
                end
                else if (!x_reg[0])
                    x_reg <= x_reg >> 1;
                else if (y_reg != '0)
                begin
                    if (!y_reg[0])
                        y_reg <= y_reg >> 1;
                    else if (x_reg > y_reg)
                    begin
                        x_reg <= y_reg; y_reg <= x_reg - y_reg;
                    end
                    else
                        y_reg <= y_reg - x_reg;
                end
                else
                begin
                    g_reg <= x_reg << sh_reg[5:0];
                    dvd_reg <= j_reg.nmag; r_reg <= '0; bit_reg <= '0;
                end
            end
            S_DIVN, S_DIVD:
            begin
                if (!rt[64])
                begin
                    r_reg <= rt[63:0]; q_reg <= {q_reg[62:0], 1'b1};
                end
                else
                begin
                    r_reg <= {r_reg[62:0], dvd_reg[63]}; q_reg <= {q_reg[62:0], 1'b0};
                end
                dvd_reg <= dvd_reg << 1;
                bit_reg <= bit_reg + 7'd1;
                if (bit_reg == 7'd63 && st_reg == S_DIVN)
                begin
                    nq_reg <= {q_reg[62:0], ~rt[64]};
                    q_reg <= '0; r_reg <= '0; dvd_reg <= j_reg.dmag; bit_reg <= '0;
                end
            end
            S_FIN:
            begin
                div_zero <= j_reg.div_zero;
                if (j_reg.is_nop)
                begin
                    res_num <= '0; res_den <= '0; order <= rau_pkg::ORD_LT;
                end
                else if (j_reg.is_cmp)
                begin
                    res_num <= '0; res_den <= '0; order <= j_reg.order;
                end
                else
                begin
                    order <= rau_pkg::ORD_LT;
                    if (j_reg.nmag == '0)
                    begin
                        res_num <= '0;
                        res_den <= (j_reg.dmag == '0) ? 62'd0 : 62'd1;
                    end
                    else if (j_reg.dmag == '0)
                    begin
                        res_num <= j_reg.neg ? -64'sd1 : 64'sd1;
                        res_den <= '0;
                    end
                    else
                    begin
                        res_num <= j_reg.neg ? signed'(-nmag_q) : signed'(nmag_q);
                        res_den <= q_reg[61:0];
                    end
                end
            end
            default: ;
        endcase
    end
endmodule

// ===== sv/rational_arith_unit.sv =====
// ----------------------------------------------------------------------------
// rational_arith_unit
// Exact add/sub/mul/div/compare of two fractions, result reduced by gcd.
// ----------------------------------------------------------------------------
//  channel | signals                                   | handshake
//  input   | action a_num a_den b_num b_den            | in_valid / in_ready
//  result  | res_num res_den order div_zero            | out_valid / out_ready
//
//  Front: operand capture, multiply, sum, hand-off; it takes no new item until the hand-off.
//  Back: binary gcd loop over 64-bit magnitudes plus two 64-step restoring
//  divisions, skipped for compare, unused codes and zero operands. The back takes
//  no new item until its result is accepted, which sets the sustained rate.
//  A two-entry queue lets the front take the next item while the back works.
//  Reset is asynchronous, clears control only.
// ----------------------------------------------------------------------------
module rational_arith_unit #(
    parameter int OPERAND_BITS = rau_pkg::OPERAND_BITS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [2:0]         action,
    input  logic signed [31:0] a_num,
    input  logic [30:0]        a_den,
    input  logic signed [31:0] b_num,
    input  logic [30:0]        b_den,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [63:0] res_num,
    output logic [61:0]        res_den,
    output logic [1:0]         order,
    output logic               div_zero
);
    rau_pkg::job_t fj, qj;
    logic fv, fr, qv, qr;

    rau_front #(.OPERAND_BITS(OPERAND_BITS)) u_front (
        .clk, .rst_n, .valid(in_valid), .ready(in_ready),
        .action, .a_num, .a_den, .b_num, .b_den,
        .job_valid(fv), .job_ready(fr), .job(fj)
    );

    rau_queue u_queue (
        .clk, .rst_n, .in_valid(fv), .in_ready(fr), .in_job(fj),
        .out_valid(qv), .out_ready(qr), .out_job(qj)
    );

    rau_back u_back (
        .clk, .rst_n, .job_valid(qv), .job_ready(qr), .job(qj),
        .valid(out_valid), .ready(out_ready),
        .res_num, .res_den, .order, .div_zero
    );
endmodule

// ===== test/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for rational_arith_unit: directed corner fractions, then
// random reduced and unreduced fractions under random idling on both channels.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    // Fraction result as the block should produce it.
    typedef struct {
        logic signed [63:0] num;
        logic [61:0]        den;
        logic [1:0]         ord;
        logic               dz;
    } frac_res_t;

    int errors = 0;

    task automatic report(input string what, input longint got, input longint want);
        errors++;
        $display("tb: mismatch %s got %0d want %0d", what, got, want);
    endtask

    // Binary gcd on magnitudes.
    function automatic logic [63:0] gcd_mag(input logic [63:0] x, input logic [63:0] y);
        int sh;
        logic [63:0] t;
        sh = 0;
        if (x == 0) return y;
        if (y == 0) return x;
        while (((x | y) & 64'd1) == 0)
        begin
            x = x >> 1;
            y = y >> 1;
            sh++;
        end
        while ((x & 64'd1) == 0) x = x >> 1;
        while (y != 0)
        begin
            while ((y & 64'd1) == 0) y = y >> 1;
            if (x > y)
            begin
                t = x;
                x = y;
                y = t;
            end
            y = y - x;
        end
        return x << sh;
    endfunction

    function automatic frac_res_t compute_fraction(input logic [2:0] act,
            input logic signed [31:0] an32, input logic [30:0] ad31,
            input logic signed [31:0] bn32, input logic [30:0] bd31);
        frac_res_t r;
        longint an, ad, bn, bd, n, d, diff;
        logic [63:0] nm, dm, g;
        logic neg;
        an = an32;
        bn = bn32;
        ad = {33'd0, ad31};
        bd = {33'd0, bd31};
        r = '{num: 0, den: 0, ord: rau_pkg::ORD_LT, dz: 1'b0};
        n = 0;
        d = 0;
        case (act)
            rau_pkg::ACT_ADD:
            begin
                n = an * bd + ad * bn;
                d = ad * bd;
            end
            rau_pkg::ACT_SUB:
            begin
                n = an * bd - ad * bn;
                d = ad * bd;
            end
            rau_pkg::ACT_MUL:
            begin
                n = an * bn;
                d = ad * bd;
            end
            rau_pkg::ACT_DIV:
            begin
                n = an * bd;
                d = ad * bn;
                r.dz = (bn == 0);
            end
            rau_pkg::ACT_CMP:
            begin
                diff = an * bd - ad * bn;
                r.ord = diff < 0 ? rau_pkg::ORD_LT
                                 : (diff == 0 ? rau_pkg::ORD_EQ : rau_pkg::ORD_GT);
                return r;
            end
            default: return r;
        endcase
        nm = n < 0 ? -n : n;
        dm = d < 0 ? -d : d;
        g = gcd_mag(nm, dm);
        if (g != 0)
        begin
            nm = nm / g;
            dm = dm / g;
        end
        neg = ((n < 0) != (d < 0)) && nm != 0;
        r.num = neg ? -nm : nm;
        r.den = dm[61:0];
        return r;
    endfunction

    class FracScoreboard;
        frac_res_t pending[$];

        function void note_input(logic [2:0] act, logic signed [31:0] an, logic [30:0] ad,
                logic signed [31:0] bn, logic [30:0] bd);
            pending.push_back(compute_fraction(act, an, ad, bn, bd));
        endfunction

        task check_result(logic signed [63:0] num, logic [61:0] den, logic [1:0] ord,
                logic dz);
            frac_res_t w;
            if (pending.size() == 0)
            begin
                report("unexpected transfer", num, 0);
                return;
            end
            w = pending.pop_front();
            if (num !== w.num) report("res_num", num, w.num);
            if (den !== w.den) report("res_den", den, w.den);
            if (ord !== w.ord) report("order", ord, w.ord);
            if (dz !== w.dz) report("div_zero", dz, w.dz);
        endtask
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic [2:0] action = '0;
    logic signed [31:0] a_num = '0;
    logic [30:0] a_den = 31'd1;
    logic signed [31:0] b_num = '0;
    logic [30:0] b_den = 31'd1;
    logic out_valid;
    logic out_ready = 1'b0;
    logic signed [63:0] res_num;
    logic [61:0] res_den;
    logic [1:0] order;
    logic div_zero;

    always #1 clk = ~clk;

    rational_arith_unit dut (.*);

    FracScoreboard sb = new();
    bit quiet_phase = 0;      // no idling in the last part of the run
    int sent = 0;
    int got = 0;
    int stall_cycles = 0;
    localparam int WATCHDOG = 40000;

    // Sample transfers at the rising edge; feed the scoreboard.
    always @(posedge clk)
    begin
        if (rst_n && in_valid && in_ready)
            sb.note_input(action, a_num, a_den, b_num, b_den);
        if (rst_n && out_valid && out_ready)
        begin
            sb.check_result(res_num, res_den, order, div_zero);
            got++;
        end
        if ((in_valid && in_ready) || (out_valid && out_ready))
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= WATCHDOG)
        begin
            $display("tb: timeout");
            $display("tb: failure");
            $finish;
        end
    end

    // Receiver: random stall bursts, ready changes at the falling edge.
    initial
    begin
        int n;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (!quiet_phase && $urandom_range(0, 5) == 0)
            begin
                out_ready <= 1'b0;
                n = $urandom_range(1, 13);
                repeat (n) @(negedge clk);
            end
            out_ready <= 1'b1;
        end
    end

    // Drive one transfer; valid stays high until accepted, caller drops it.
    task automatic send_item(logic [2:0] act, logic signed [31:0] an, logic [30:0] ad,
            logic signed [31:0] bn, logic [30:0] bd);
        int n;
        if (!quiet_phase && $urandom_range(0, 4) == 0)
        begin
            in_valid <= 1'b0;
            n = $urandom_range(1, 13);
            repeat (n) @(negedge clk);
        end
        in_valid <= 1'b1;
        action <= act;
        a_num <= an;
        a_den <= ad;
        b_num <= bn;
        b_den <= bd;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        @(negedge clk);
        sent++;
    endtask

    function automatic logic signed [31:0] rand_num();
        case ($urandom_range(0, 4))
            0: return $signed(32'($urandom_range(0, 20))) - 10;
            1: return $urandom_range(0, 1) ? 32'sh7fffffff : -32'sh7fffffff;
            2: return $signed(32'($urandom_range(0, 2000))) - 1000;
            default: return $signed($urandom());
        endcase
    endfunction

    function automatic logic [30:0] rand_den();
        case ($urandom_range(0, 3))
            0: return 31'($urandom_range(1, 12));
            1: return 31'h7fffffff - 31'($urandom_range(0, 3));
            default: return 31'($urandom_range(1, 32'h7fffffff));
        endcase
    endfunction

    initial
    begin
        logic [2:0] act;
        logic signed [31:0] an, bn;
        logic [30:0] ad, bd;
        int ops[5];
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: every action, extremes, zero operands, divide by zero,
        // equal compare, unused action codes, out-of-range zero denominator
        // and most negative numerator.
        send_item(rau_pkg::ACT_ADD, 32'sd1, 31'd2, 32'sd1, 31'd3);
        send_item(rau_pkg::ACT_SUB, 32'sd1, 31'd2, 32'sd1, 31'd2);
        send_item(rau_pkg::ACT_MUL, -32'sd3, 31'd4, 32'sd4, 31'd9);
        send_item(rau_pkg::ACT_DIV, 32'sd5, 31'd7, -32'sd10, 31'd7);
        send_item(rau_pkg::ACT_DIV, 32'sd5, 31'd7, 32'sd0, 31'd1);
        send_item(rau_pkg::ACT_DIV, -32'sd5, 31'd7, 32'sd0, 31'd1);
        send_item(rau_pkg::ACT_DIV, 32'sd0, 31'd1, 32'sd0, 31'd1);
        send_item(rau_pkg::ACT_CMP, 32'sd1, 31'd2, 32'sd2, 31'd4);
        send_item(rau_pkg::ACT_CMP, -32'sd1, 31'd2, 32'sd1, 31'd3);
        send_item(rau_pkg::ACT_CMP, 32'sd1, 31'd2, 32'sd1, 31'd3);
        send_item(rau_pkg::ACT_ADD, 32'sh7fffffff, 31'h7fffffff, 32'sh7fffffff,
                  31'h7fffffff);
        send_item(rau_pkg::ACT_MUL, -32'sh7fffffff, 31'd1, -32'sh7fffffff, 31'h7ffffffe);
        send_item(rau_pkg::ACT_SUB, -32'sh7fffffff, 31'd1, 32'sh7fffffff, 31'd1);
        send_item(rau_pkg::ACT_MUL, 32'sd0, 31'd5, 32'sd9, 31'd2);
        send_item(3'd5, 32'sd1, 31'd1, 32'sd1, 31'd1);
        send_item(3'd6, -32'sd1, 31'd3, 32'sd7, 31'd1);
        send_item(3'd7, 32'sd9, 31'd9, 32'sd9, 31'd9);
        send_item(rau_pkg::ACT_ADD, 32'sd3, 31'd0, 32'sd1, 31'd2);
        send_item(rau_pkg::ACT_MUL, -32'sd3, 31'd0, 32'sd1, 31'd0);
        send_item(rau_pkg::ACT_DIV, 32'sh80000000, 31'd1, 32'sh80000000, 31'd3);
        send_item(rau_pkg::ACT_CMP, 32'sh80000000, 31'h7fffffff, 32'sh7fffffff, 31'd0);
        in_valid <= 1'b0;

        // Let everything drain before the random part.
        while (sb.pending.size() != 0) @(negedge clk);

        for (int i = 0; i < 1850; i++)
        begin
            if (i == 1600) quiet_phase = 1;
            act = $urandom_range(0, 19) == 0 ? 3'($urandom_range(5, 7))
                                             : 3'($urandom_range(0, 4));
            if (act < 5) ops[act]++;
            an = rand_num();
            bn = $urandom_range(0, 9) == 0 ? 32'sd0 : rand_num();
            ad = rand_den();
            bd = rand_den();
            if ($urandom_range(0, 15) == 0)
            begin
                bn = an;
                bd = ad;
            end
            if ($urandom_range(0, 99) == 0) ad = 31'd0;
            send_item(act, an, ad, bn, bd);
        end
        in_valid <= 1'b0;

        while (sb.pending.size() != 0) @(negedge clk);
        repeat (400) @(negedge clk);
        $display("tb: %0d transfers in, %0d results checked", sent, got);
        $display("tb: random mix add %0d sub %0d mul %0d div %0d cmp %0d",
                 ops[0], ops[1], ops[2], ops[3], ops[4]);
        if (errors == 0 && sb.pending.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
